@@ src/htc_pkg.sv @@
// Shared types, constants and helpers for the HTML text cleaner.
package htc_pkg;

  typedef enum logic [3:0] {
    PH_IDLE, PH_NAMED, PH_HASH, PH_START, PH_WS, PH_SIGN, PH_ZERO, PH_PREFIX, PH_DIGITS
  } ph_e;

  typedef enum logic [2:0] {
    BK_IDLE, BK_TAKE, BK_REPLAY, BK_ENC, BK_EOFCHK, BK_DRAIN
  } bk_st_e;

  typedef struct packed {
    logic       chv;
    logic [7:0] chr;
    logic       eof;
  } item_t;

  localparam int NUM_ENT = 5;
  localparam int MAX_RES = 32;
  localparam int RES_IW  = 5;
  localparam int RES_CW  = 6;

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_XU    = 8'h58;

  localparam logic [7:0] UTF_CONT  = 8'h80;
  localparam logic [7:0] UTF_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF_LEAD4 = 8'hF0;

  localparam logic [2:0] ENT_LEN [NUM_ENT] = '{3'd5, 3'd4, 3'd4, 3'd6, 3'd6};
  localparam logic [7:0] ENT_CODE[NUM_ENT] = '{8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27};
  localparam logic [7:0] ENT_TEXT[NUM_ENT][6] = '{
    '{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},
    '{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},
    '{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},
    '{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},
    '{8'h26, 8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B}
  };

  function automatic logic is_ws(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D) ||
           (b == 8'h0C) || (b == 8'h0B);
  endfunction

endpackage

@@ src/html_text_cleaner.sv @@
// Top level of the HTML text cleaner: tag stripper, item queue and decoder back end.
// A byte passes the back end through the take, end check and drain states, and its result beats
//   wait in drain for the sink; a bare end mark skips take. A decoded entity is sent one UTF-8 byte
//   at a time from the encode state, and a failed entity replays its buffered bytes. The back end
//   takes no new item until it is back in idle. The two-entry queue decouples the input.
// Reset is asynchronous, active low; it clears all control state, no clearing pass.
module html_text_cleaner #(
  parameter int PENDING_DEPTH = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,      // out_buffer_size
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] raw_byte
  input  logic        s_axis_tlast_i,   // end_of_fragment
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] out_byte
  output logic [1:0]  m_axis_tuser_o,   // [0] byte_valid, [1] truncated
  output logic        m_axis_tlast_o    // end_of_result
);
  import htc_pkg::*;

  item_t f_item, q_item;
  logic  f_push, q_rdy, q_vld, q_pop;

  htc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .push_o         (f_push),
    .item_o         (f_item),
    .push_ready_i   (q_rdy)
  );

  htc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (f_push),
    .item_i      (f_item),
    .push_ready_o(q_rdy),
    .pop_i       (q_pop),
    .item_o      (q_item),
    .pop_valid_o (q_vld)
  );

  htc_back #(.PENDING_DEPTH(PENDING_DEPTH)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .item_valid_i   (q_vld),
    .item_i         (q_item),
    .item_pop_o     (q_pop),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  // a bare marker only ever closes a fragment
  a_bare_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tlast_o)
    else $error("bare beat without tlast");

  a_bare_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o == 8'h00)
    else $error("bare beat carries data");

  a_trunc_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o && m_axis_tuser_o[1]
    |=> !m_axis_tvalid_o || m_axis_tuser_o[1])
    else $error("truncated dropped within a fragment");

endmodule

@@ src/htc_front.sv @@
// Front end: accepts input beats and strips markup tags.
module htc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [7:0]          s_axis_tdata_i,   // [7:0] raw_byte
  input  logic                s_axis_tlast_i,   // end_of_fragment
  output logic                push_o,
  output htc_pkg::item_t      item_o,
  input  logic                push_ready_i
);
  import htc_pkg::*;

  logic inside_q, inside_d;
  logic acc;

  assign s_axis_tready_o = push_ready_i;
  assign acc = s_axis_tvalid_i && push_ready_i;

  always_comb begin
    inside_d   = inside_q;
    item_o.chr = s_axis_tdata_i;
    item_o.eof = s_axis_tlast_i;
    item_o.chv = 1'b0;
    if (s_axis_tdata_i == CH_LT) begin
      item_o.chr = CH_SP;
      item_o.chv = 1'b1;
      inside_d   = 1'b1;
    end else if (s_axis_tdata_i == CH_GT) begin
      inside_d = 1'b0;
    end else begin
      item_o.chv = !inside_q;
    end
    if (s_axis_tlast_i) inside_d = 1'b0;
  end

  // beats with nothing left to do are dropped here
  assign push_o = acc && (item_o.chv || item_o.eof);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
    end else if (acc) begin
      inside_q <= inside_d;
    end
  end

endmodule

@@ src/htc_queue.sv @@
// Short item queue between front end and back end.
module htc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  htc_pkg::item_t item_i,
  output logic           push_ready_o,
  input  logic           pop_i,
  output htc_pkg::item_t item_o,
  output logic           pop_valid_o
);
  import htc_pkg::*;

  item_t       mem_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign item_o       = mem_q[rp_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wp_q <= !wp_q;
      if (do_pop)  rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

@@ src/htc_back.sv @@
// Back end: entity decoding, UTF-8 encoding, whitespace collapsing and output.
module htc_back #(
  parameter int PENDING_DEPTH = 24
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [15:0]    cfg_wdata_i,
  input  logic           item_valid_i,
  input  htc_pkg::item_t item_i,
  output logic           item_pop_o,
  output logic           m_axis_tvalid_o,
  input  logic           m_axis_tready_i,
  output logic [7:0]     m_axis_tdata_o,   // [7:0] out_byte
  output logic [1:0]     m_axis_tuser_o,   // [0] byte_valid, [1] truncated
  output logic           m_axis_tlast_o    // end_of_result
);
  import htc_pkg::*;

  localparam int DEPTH = (PENDING_DEPTH < 2) ? 2 : ((PENDING_DEPTH > 29) ? 29 : PENDING_DEPTH);
  localparam int LW    = $clog2(DEPTH + 1);
  localparam int IW    = $clog2(DEPTH);

  bk_st_e          st_q, st_d;
  logic [7:0]      sc_q, sc_d;
  logic            eof_q, eof_d;
  ph_e             ph_q, ph_d;
  logic [LW-1:0]   elen_q, elen_d;
  logic [7:0]      ebuf_q [DEPTH];
  logic [NUM_ENT-1:0] mask_q, mask_d;
  logic            hex_q, hex_d, neg_q, neg_d, sat_q, sat_d;
  logic [63:0]     val_q, val_d;
  logic [31:0]     cp_q, cp_d;
  logic [1:0]      enc_n_q, enc_n_d, enc_k_q, enc_k_d;
  logic [LW-1:0]   rp_idx_q, rp_idx_d, rp_n_q, rp_n_d;
  logic            ret_q, ret_d;
  logic            spc_q, spc_d, txt_q, txt_d, trunc_q, trunc_d;
  logic [15:0]     bw_q, bw_d, obs_q;
  logic [7:0]      rbuf_q [MAX_RES];
  logic [RES_CW-1:0] rcnt_q, rcnt_d;
  logic [RES_IW-1:0] didx_q, didx_d;

  // entity take decode
  ph_e             ph_eff, tk_next, nx;
  logic            tk_ok, tk_fin, tk_push, tk_neg, tk_acc, tk_hexset;
  logic [31:0]     tk_cp, num_cp;
  logic [NUM_ENT-1:0] mv;
  logic [2:0]      first;
  logic            full, d_ok, go, dig, dig2;
  logic [3:0]      d_val;
  logic [67:0]     prod, lim;
  logic            ovf;

  // writer
  logic            wr_en, cap_ok, wr_ws, wr_put;
  logic [7:0]      wr_b, enc_b;
  logic            ebuf_we;
  logic [IW-1:0]   ebuf_wa;
  logic [7:0]      ebuf_wd;
  logic [RES_CW-1:0] r1;
  logic            last_idx, drain_done;

  // digit value
  always_comb begin
    d_ok  = 1'b0;
    d_val = 4'd0;
    if (sc_q >= 8'h30 && sc_q <= 8'h39) begin
      d_ok  = 1'b1;
      d_val = sc_q[3:0];
    end else if (hex_q && ((sc_q >= 8'h61 && sc_q <= 8'h66) ||
                           (sc_q >= 8'h41 && sc_q <= 8'h46))) begin
      d_ok  = 1'b1;
      d_val = sc_q[3:0] + 4'd9;
    end
  end

  always_comb begin
    prod = hex_q ? {val_q, 4'b0} : (({4'b0, val_q} << 3) + ({4'b0, val_q} << 1));
    prod = prod + {64'b0, d_val};
    lim  = neg_q ? {4'b0, 1'b1, 63'b0} : {5'b0, {63{1'b1}}};
    ovf  = prod > lim;
    if (sat_q) num_cp = neg_q ? 32'h0 : 32'hFFFF_FFFF;
    else       num_cp = neg_q ? (32'h0 - val_q[31:0]) : val_q[31:0];
  end

  always_comb begin
    tk_ok     = 1'b0;
    tk_fin    = 1'b0;
    tk_cp     = 32'h0;
    tk_push   = 1'b0;
    tk_next   = ph_q;
    tk_neg    = 1'b0;
    tk_acc    = 1'b0;
    tk_hexset = 1'b0;
    mv        = '0;
    first     = 3'd0;
    go        = 1'b0;
    dig       = 1'b0;
    dig2      = 1'b0;
    nx        = ph_q;
    full      = elen_q >= LW'(DEPTH);
    ph_eff    = (ph_q == PH_HASH) ? PH_START : ph_q;
    for (int k = 0; k < NUM_ENT; k++) begin
      mv[k] = mask_q[k] && (elen_q < LW'(ENT_LEN[k])) &&
              (ENT_TEXT[k][elen_q[2:0]] == sc_q);
    end
    for (int k = NUM_ENT - 1; k >= 0; k--) begin
      if (mv[k]) first = 3'(k);
    end
    if (ph_q == PH_NAMED) begin
      if (elen_q == LW'(1) && sc_q == CH_HASH) begin
        tk_ok   = !full;
        tk_push = 1'b1;
        tk_next = PH_HASH;
      end else if (|mv) begin
        if (elen_q + LW'(1) == LW'(ENT_LEN[first])) begin
          tk_ok  = 1'b1;
          tk_fin = 1'b1;
          tk_cp  = {24'h0, ENT_CODE[first]};
        end else begin
          tk_ok   = !full;
          tk_push = 1'b1;
          tk_next = PH_NAMED;
        end
      end
    end else if (ph_q == PH_HASH && (sc_q == CH_X || sc_q == CH_XU)) begin
      tk_ok     = !full;
      tk_push   = 1'b1;
      tk_next   = PH_START;
      tk_hexset = 1'b1;
    end else if (sc_q == CH_SEMI) begin
      if (ph_eff == PH_START || ph_eff == PH_ZERO || ph_eff == PH_DIGITS) begin
        tk_ok  = 1'b1;
        tk_fin = 1'b1;
        tk_cp  = num_cp;
      end
    end else begin
      unique case (ph_eff)
        PH_START, PH_WS: begin
          if (is_ws(sc_q)) begin
            go = 1'b1;
            nx = PH_WS;
          end else if (sc_q == CH_PLUS || sc_q == CH_MINUS) begin
            go     = 1'b1;
            nx     = PH_SIGN;
            tk_neg = (sc_q == CH_MINUS);
          end else begin
            dig = 1'b1;
          end
        end
        PH_SIGN: dig = 1'b1;
        PH_ZERO: begin
          if (sc_q == CH_X || sc_q == CH_XU) begin
            go = 1'b1;
            nx = PH_PREFIX;
          end else begin
            dig2 = 1'b1;
          end
        end
        PH_PREFIX, PH_DIGITS: dig2 = 1'b1;
        default: ;
      endcase
      if (dig && d_ok) begin
        go = 1'b1;
        if (hex_q && sc_q == CH_ZERO) begin
          nx = PH_ZERO;
        end else begin
          nx     = PH_DIGITS;
          tk_acc = 1'b1;
        end
      end
      if (dig2 && d_ok) begin
        go     = 1'b1;
        nx     = PH_DIGITS;
        tk_acc = 1'b1;
      end
      if (go) begin
        tk_ok   = !full;
        tk_push = 1'b1;
        tk_next = nx;
      end
    end
  end

  // UTF-8 byte k of an (n+1)-byte sequence
  always_comb begin
    enc_b = cp_q[7:0];
    if (enc_k_q == 2'd0) begin
      unique case (enc_n_q)
        2'd0: enc_b = cp_q[7:0];
        2'd1: enc_b = UTF_LEAD2 | {3'b0, cp_q[10:6]};
        2'd2: enc_b = UTF_LEAD3 | {4'b0, cp_q[15:12]};
        2'd3: enc_b = UTF_LEAD4 | cp_q[25:18];
        default: ;
      endcase
    end else begin
      unique case (enc_n_q - enc_k_q)
        2'd1: enc_b = UTF_CONT | {2'b0, cp_q[11:6]};
        2'd2: enc_b = UTF_CONT | {2'b0, cp_q[17:12]};
        default: enc_b = UTF_CONT | {2'b0, cp_q[5:0]};
      endcase
    end
  end

  always_comb begin
    wr_en = 1'b0;
    wr_b  = sc_q;
    unique case (st_q)
      BK_TAKE:   wr_en = (ph_q == PH_IDLE) && (sc_q != CH_AMP);
      BK_REPLAY: begin
        wr_en = 1'b1;
        wr_b  = ebuf_q[rp_idx_q[IW-1:0]];
      end
      BK_ENC: begin
        wr_en = 1'b1;
        wr_b  = enc_b;
      end
      default: ;
    endcase
    cap_ok = ({1'b0, bw_q} + 17'd8) < {1'b0, obs_q};
    wr_ws  = is_ws(wr_b);
    wr_put = wr_en && cap_ok && !wr_ws;
  end

  assign r1         = rcnt_q + RES_CW'(1);
  assign last_idx   = ({1'b0, didx_q} == rcnt_q - RES_CW'(1));
  assign drain_done = (rcnt_q == '0) ? (!eof_q || m_axis_tready_i)
                                     : (m_axis_tready_i && last_idx);

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      BK_IDLE:   if (item_valid_i) st_d = item_i.chv ? BK_TAKE : BK_EOFCHK;
      BK_TAKE: begin
        if (ph_q != PH_IDLE) begin
          if (tk_ok) st_d = tk_fin ? BK_ENC : BK_EOFCHK;
          else       st_d = BK_REPLAY;
        end else begin
          st_d = BK_EOFCHK;
        end
      end
      BK_REPLAY: if (rp_idx_q == rp_n_q - LW'(1)) st_d = ret_q ? BK_TAKE : BK_DRAIN;
      BK_ENC:    if (enc_k_q == enc_n_q) st_d = BK_EOFCHK;
      BK_EOFCHK: st_d = (eof_q && ph_q != PH_IDLE) ? BK_REPLAY : BK_DRAIN;
      BK_DRAIN:  if (drain_done) st_d = BK_IDLE;
      default:   st_d = BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    sc_d     = sc_q;
    eof_d    = eof_q;
    ph_d     = ph_q;
    elen_d   = elen_q;
    mask_d   = mask_q;
    hex_d    = hex_q;
    neg_d    = neg_q;
    sat_d    = sat_q;
    val_d    = val_q;
    cp_d     = cp_q;
    enc_n_d  = enc_n_q;
    enc_k_d  = enc_k_q;
    rp_idx_d = rp_idx_q;
    rp_n_d   = rp_n_q;
    ret_d    = ret_q;
    spc_d    = spc_q;
    txt_d    = txt_q;
    trunc_d  = trunc_q;
    bw_d     = bw_q;
    rcnt_d   = rcnt_q;
    didx_d   = didx_q;
    ebuf_we  = 1'b0;
    ebuf_wa  = elen_q[IW-1:0];
    ebuf_wd  = sc_q;

    if (wr_en) begin
      if (!cap_ok) begin
        if (!wr_ws) trunc_d = 1'b1;
      end else if (wr_ws) begin
        if (txt_q) spc_d = 1'b1;
      end else begin
        bw_d  = bw_q + (spc_q ? 16'd2 : 16'd1);
        spc_d = 1'b0;
        txt_d = 1'b1;
        if (spc_q) rcnt_d = (r1 >= RES_CW'(MAX_RES)) ? RES_CW'(MAX_RES) : r1 + RES_CW'(1);
        else       rcnt_d = (rcnt_q >= RES_CW'(MAX_RES)) ? RES_CW'(MAX_RES) : r1;
      end
    end

    unique case (st_q)
      BK_IDLE: begin
        if (item_valid_i) begin
          sc_d  = item_i.chr;
          eof_d = item_i.eof;
        end
      end
      BK_TAKE: begin
        if (ph_q != PH_IDLE) begin
          if (tk_ok && tk_fin) begin
            ph_d    = PH_IDLE;
            elen_d  = '0;
            val_d   = '0;
            sat_d   = 1'b0;
            neg_d   = 1'b0;
            hex_d   = 1'b0;
            cp_d    = tk_cp;
            enc_k_d = 2'd0;
            if (tk_cp < 32'h80)         enc_n_d = 2'd0;
            else if (tk_cp < 32'h800)   enc_n_d = 2'd1;
            else if (tk_cp < 32'h10000) enc_n_d = 2'd2;
            else                        enc_n_d = 2'd3;
          end else if (tk_ok) begin
            ebuf_we = tk_push;
            elen_d  = elen_q + LW'(1);
            ph_d    = tk_next;
            mask_d  = mv;
            if (tk_hexset) hex_d = 1'b1;
            if (tk_neg) neg_d = 1'b1;
            if (tk_acc && !sat_q) begin
              if (ovf) sat_d = 1'b1;
              else     val_d = prod[63:0];
            end
          end else begin
            rp_n_d   = elen_q;
            rp_idx_d = '0;
            ret_d    = 1'b1;
            ph_d     = PH_IDLE;
            elen_d   = '0;
            val_d    = '0;
            sat_d    = 1'b0;
            neg_d    = 1'b0;
            hex_d    = 1'b0;
          end
        end else if (sc_q == CH_AMP) begin
          ebuf_we = 1'b1;
          ebuf_wa = '0;
          ebuf_wd = CH_AMP;
          elen_d  = LW'(1);
          ph_d    = PH_NAMED;
          mask_d  = '1;
        end
      end
      BK_REPLAY: rp_idx_d = rp_idx_q + LW'(1);
      BK_ENC:    enc_k_d = enc_k_q + 2'd1;
      BK_EOFCHK: begin
        if (eof_q && ph_q != PH_IDLE) begin
          rp_n_d   = elen_q;
          rp_idx_d = '0;
          ret_d    = 1'b0;
          ph_d     = PH_IDLE;
          elen_d   = '0;
          val_d    = '0;
          sat_d    = 1'b0;
          neg_d    = 1'b0;
          hex_d    = 1'b0;
        end
      end
      BK_DRAIN: begin
        if (m_axis_tready_i) didx_d = didx_q + RES_IW'(1);
        if (drain_done) begin
          rcnt_d = '0;
          didx_d = '0;
          if (eof_q) begin
            spc_d   = 1'b0;
            txt_d   = 1'b0;
            trunc_d = 1'b0;
            bw_d    = '0;
          end
        end
      end
      default: ;
    endcase

    item_pop_o      = (st_q == BK_IDLE);
    m_axis_tvalid_o = (st_q == BK_DRAIN) && ((rcnt_q != '0) || eof_q);
    m_axis_tdata_o  = (rcnt_q != '0) ? rbuf_q[didx_q] : 8'h00;
    m_axis_tuser_o  = {trunc_q, (rcnt_q != '0)};
    m_axis_tlast_o  = eof_q && ((rcnt_q == '0) || last_idx);
  end

  always_ff @(posedge clk_i) begin
    if (ebuf_we) ebuf_q[ebuf_wa] <= ebuf_wd;
    if (wr_put) begin
      if (rcnt_q < RES_CW'(MAX_RES)) rbuf_q[rcnt_q[RES_IW-1:0]] <= spc_q ? CH_SP : wr_b;
      if (spc_q && r1 < RES_CW'(MAX_RES)) rbuf_q[r1[RES_IW-1:0]] <= wr_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= BK_IDLE;
      sc_q     <= '0;
      eof_q    <= 1'b0;
      ph_q     <= PH_IDLE;
      elen_q   <= '0;
      mask_q   <= '0;
      hex_q    <= 1'b0;
      neg_q    <= 1'b0;
      sat_q    <= 1'b0;
      val_q    <= '0;
      cp_q     <= '0;
      enc_n_q  <= '0;
      enc_k_q  <= '0;
      rp_idx_q <= '0;
      rp_n_q   <= '0;
      ret_q    <= 1'b0;
      spc_q    <= 1'b0;
      txt_q    <= 1'b0;
      trunc_q  <= 1'b0;
      bw_q     <= '0;
      obs_q    <= 16'd1024;
      rcnt_q   <= '0;
      didx_q   <= '0;
    end else begin
      st_q     <= st_d;
      sc_q     <= sc_d;
      eof_q    <= eof_d;
      ph_q     <= ph_d;
      elen_q   <= elen_d;
      mask_q   <= mask_d;
      hex_q    <= hex_d;
      neg_q    <= neg_d;
      sat_q    <= sat_d;
      val_q    <= val_d;
      cp_q     <= cp_d;
      enc_n_q  <= enc_n_d;
      enc_k_q  <= enc_k_d;
      rp_idx_q <= rp_idx_d;
      rp_n_q   <= rp_n_d;
      ret_q    <= ret_d;
      spc_q    <= spc_d;
      txt_q    <= txt_d;
      trunc_q  <= trunc_d;
      bw_q     <= bw_d;
      rcnt_q   <= rcnt_d;
      didx_q   <= didx_d;
      if (cfg_we_i) obs_q <= cfg_wdata_i;
    end
  end

endmodule

@@ tb/html_text_cleaner_test.sv @@
// Self-checking testbench for the HTML text cleaner: directed and random stream beats against a predictor.
`timescale 1ns / 100ps

class htc_scoreboard;
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic       trunc;
  } cln_beat_t;

  localparam int DEPTH_USED = 24;

  typedef enum int {
    EP_IDLE, EP_NAMED, EP_HASH, EP_START, EP_WS, EP_SIGN, EP_ZERO, EP_PREFIX, EP_DIGITS
  } ent_ph_e;

  logic [15:0] buf_size;
  bit          in_tag, sp_pend, started, trunc_flag;
  int unsigned wr_count;
  logic [7:0]  ent_buf [32];
  int          ent_len;
  ent_ph_e     ent_ph;
  logic [63:0] num_val;
  bit          num_sat, num_neg;
  cln_beat_t   step_q[$];
  cln_beat_t   expect_q[$];
  int          errors;
  int          beats_checked;
  int          frags;

  function new();
    buf_size = 16'd1024;
    errors = 0;
    beats_checked = 0;
    frags = 0;
    foreach (ent_buf[i]) ent_buf[i] = 8'h00;
    clear_frag();
  endfunction

  function bit ws(logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D || c == 8'h0C || c == 8'h0B;
  endfunction

  function void clear_ent();
    ent_ph = EP_IDLE;
    ent_len = 0;
    num_val = 0;
    num_sat = 0;
    num_neg = 0;
  endfunction

  function void clear_frag();
    in_tag = 0;
    sp_pend = 0;
    started = 0;
    trunc_flag = 0;
    wr_count = 0;
    clear_ent();
  endfunction

  function void emit(logic [7:0] b);
    cln_beat_t r;
    if (step_q.size() >= 32) return;
    r = '{data: b, valid: 1'b1, last: 1'b0, trunc: 1'b0};
    step_q.push_back(r);
  endfunction

  function void write_byte(logic [7:0] b);
    if (!(wr_count + 8 < buf_size)) begin
      if (!ws(b)) trunc_flag = 1;
      return;
    end
    if (ws(b)) begin
      if (started) sp_pend = 1;
      return;
    end
    if (sp_pend) begin
      emit(8'h20);
      wr_count++;
      sp_pend = 0;
    end
    emit(b);
    wr_count++;
    started = 1;
  endfunction

  function void encode(logic [31:0] cp);
    logic [31:0] t;
    if (cp < 32'h80) write_byte(cp[7:0]);
    else if (cp < 32'h800) begin
      t = 32'hC0 | (cp >> 6);
      write_byte(t[7:0]);
      write_byte(8'h80 | cp[5:0]);
    end else if (cp < 32'h10000) begin
      t = 32'hE0 | (cp >> 12);
      write_byte(t[7:0]);
      write_byte(8'h80 | cp[11:6]);
      write_byte(8'h80 | cp[5:0]);
    end else begin
      t = 32'hF0 | (cp >> 18);
      write_byte(t[7:0]);
      write_byte(8'h80 | cp[17:12]);
      write_byte(8'h80 | cp[11:6]);
      write_byte(8'h80 | cp[5:0]);
    end
  endfunction

  function void finish_ent(logic [31:0] cp);
    clear_ent();
    encode(cp);
  endfunction

  function void replay();
    int n;
    n = ent_len;
    clear_ent();
    for (int i = 0; i < n && i < DEPTH_USED; i++) write_byte(ent_buf[i]);
  endfunction

  function bit push(logic [7:0] c);
    if (ent_len >= DEPTH_USED) return 0;
    ent_buf[ent_len] = c;
    ent_len++;
    return 1;
  endfunction

  function int digit(logic [7:0] c, bit hex);
    if (c >= "0" && c <= "9") return c - "0";
    if (hex && c >= "a" && c <= "f") return c - "a" + 10;
    if (hex && c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function void accumulate(int d, bit hex);
    logic [63:0] base, lim;
    base = hex ? 64'd16 : 64'd10;
    lim = num_neg ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF;
    if (num_sat) return;
    if (num_val > (lim - 64'(d)) / base) num_sat = 1;
    else num_val = num_val * base + 64'(d);
  endfunction

  function logic [31:0] num_cp();
    logic [63:0] v;
    if (num_sat) v = num_neg ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF;
    else v = num_neg ? (64'd0 - num_val) : num_val;
    return v[31:0];
  endfunction

  function bit named_match(int k, int len, logic [7:0] c);
    string names[5];
    string s;
    names = '{"&amp;", "&lt;", "&gt;", "&quot;", "&apos;"};
    s = names[k];
    if (len >= s.len() || s[len] != c) return 0;
    for (int i = 0; i < len; i++) if (s[i] != ent_buf[i]) return 0;
    return 1;
  endfunction

  function bit ent_take(logic [7:0] c);
    logic [7:0] codes[5];
    int lens[5];
    bit hex, neg, acc;
    int d, len;
    ent_ph_e nxt;
    codes = '{"&", "<", ">", 8'h22, 8'h27};
    lens = '{5, 4, 4, 6, 6};
    neg = 0;
    acc = 0;
    if (ent_ph == EP_NAMED) begin
      len = ent_len;
      if (len == 1 && c == "#") begin
        if (!push(c)) return 0;
        ent_ph = EP_HASH;
        return 1;
      end
      for (int k = 0; k < 5; k++) begin
        if (named_match(k, len, c)) begin
          if (len + 1 == lens[k]) begin
            finish_ent({24'd0, codes[k]});
            return 1;
          end
          return push(c);
        end
      end
      return 0;
    end
    if (ent_ph == EP_HASH) begin
      if (c == "x" || c == "X") begin
        if (!push(c)) return 0;
        ent_ph = EP_START;
        return 1;
      end
      ent_ph = EP_START;
    end
    hex = ent_len >= 3 && (ent_buf[2] == "x" || ent_buf[2] == "X");
    d = digit(c, hex);
    if (c == ";") begin
      if (ent_ph == EP_START || ent_ph == EP_ZERO || ent_ph == EP_DIGITS) begin
        finish_ent(num_cp());
        return 1;
      end
      return 0;
    end
    nxt = EP_IDLE;
    case (ent_ph)
      EP_START, EP_WS, EP_SIGN: begin
        if (ent_ph != EP_SIGN && ws(c)) nxt = EP_WS;
        else if (ent_ph != EP_SIGN && (c == "+" || c == "-")) begin
          nxt = EP_SIGN;
          neg = (c == "-");
        end else begin
          if (d < 0) return 0;
          if (hex && c == "0") nxt = EP_ZERO;
          else begin
            nxt = EP_DIGITS;
            acc = 1;
          end
        end
      end
      EP_ZERO, EP_PREFIX, EP_DIGITS: begin
        if (ent_ph == EP_ZERO && (c == "x" || c == "X")) nxt = EP_PREFIX;
        else begin
          if (d < 0) return 0;
          nxt = EP_DIGITS;
          acc = 1;
        end
      end
      default: return 0;
    endcase
    if (!push(c)) return 0;
    if (neg) num_neg = 1;
    if (acc) accumulate(d, hex);
    ent_ph = nxt;
    return 1;
  endfunction

  function void decode(logic [7:0] c);
    if (ent_ph != EP_IDLE) begin
      if (ent_take(c)) return;
      replay();
    end
    if (c == "&") begin
      ent_buf[0] = "&";
      ent_len = 1;
      ent_ph = EP_NAMED;
    end else write_byte(c);
  endfunction

  function void note_input(logic [7:0] c, bit eof);
    cln_beat_t r;
    step_q.delete();
    if (c == "<") begin
      in_tag = 1;
      decode(8'h20);
    end else if (c == ">") in_tag = 0;
    else if (!in_tag) decode(c);
    if (eof && ent_ph != EP_IDLE) replay();
    foreach (step_q[k]) step_q[k].trunc = trunc_flag;
    if (eof) begin
      if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1;
      else begin
        r = '{data: 8'h00, valid: 1'b0, last: 1'b1, trunc: trunc_flag};
        step_q.push_back(r);
      end
      clear_frag();
      frags++;
    end
    foreach (step_q[k]) expect_q.push_back(step_q[k]);
  endfunction

  function void check_result(logic [7:0] data, logic [1:0] user, logic last);
    cln_beat_t e;
    beats_checked++;
    if (expect_q.size() == 0) begin
      $error("unexpected beat data=%h user=%b last=%b", data, user, last);
      errors++;
      return;
    end
    e = expect_q.pop_front();
    if (data !== e.data) begin
      $error("out_byte expected %h actual %h", e.data, data);
      errors++;
    end
    if (user[0] !== e.valid) begin
      $error("byte_valid expected %b actual %b", e.valid, user[0]);
      errors++;
    end
    if (user[1] !== e.trunc) begin
      $error("truncated expected %b actual %b", e.trunc, user[1]);
      errors++;
    end
    if (last !== e.last) begin
      $error("end_of_result expected %b actual %b", e.last, last);
      errors++;
    end
  endfunction
endclass

module html_text_cleaner_test;
  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [15:0] cfg_wdata_i = 0;
  logic        s_axis_tvalid_i = 0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 0;
  logic        s_axis_tlast_i = 0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 0;
  logic [7:0]  m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  htc_scoreboard sb = new();
  int  idle_cnt;
  bit  src_done;
  bit  timed_out;
  int  beats_sent;

  html_text_cleaner i_dut (.*);

  initial forever #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) sb.note_input(s_axis_tdata_i, s_axis_tlast_i);
    if (m_axis_tvalid_o && m_axis_tready_i)
      sb.check_result(m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt > 5000 && !timed_out) begin
      timed_out = 1;
      $display("html_text_cleaner_test failed");
      $finish;
    end
  end

  // Sink: random stall per beat, with stall-free stretches.
  initial begin
    int w;
    idle_cnt = 0;
    @(posedge rst_ni);
    forever begin
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (w > 0) begin
        m_axis_tready_i <= 0;
        repeat (w) @(posedge clk_i);
      end
      m_axis_tready_i <= 1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
    end
  end

  task automatic send(input logic [7:0] b, input bit eof, input bit no_gap = 0);
    int w;
    w = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
    if (w > 0) begin
      s_axis_tvalid_i <= 0;
      repeat (w) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1;
    s_axis_tdata_i <= b;
    s_axis_tlast_i <= eof;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic send_str(input string s, input bit eof);
    for (int i = 0; i < s.len(); i++) send(s[i], eof && i == s.len() - 1);
  endtask

  task automatic quiesce();
    s_axis_tvalid_i <= 0;
    @(posedge clk_i);
    while (sb.expect_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_size(input logic [15:0] v);
    quiesce();
    cfg_we_i <= 1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.buf_size = v;
  endtask

  function automatic logic [7:0] pick_byte();
    string alpha;
    alpha = "amplgtquosx#;&<> \t0123456789abcdefABCDEFX+-\n";
    case ($urandom_range(0, 9))
      0: return 8'($urandom_range(0, 255));
      default: return alpha[$urandom_range(0, alpha.len() - 1)];
    endcase
  endfunction

  task automatic send_entity();
    string ents[12];
    string s;
    int n;
    ents = '{"&amp;", "&lt;", "&gt;", "&quot;", "&apos;", "&#", "&#x", "&# -",
             "&#x 0x", "&#+", "&am", "&#x0"};
    s = ents[$urandom_range(0, 11)];
    n = $urandom_range(0, 12);
    for (int i = 0; i < n && s.len() > 1 && s[1] == "#"; i++)
      s = {s, string'(pick_byte())};
    if ($urandom_range(0, 4) != 0) s = {s, ";"};
    send_str(s, 0);
  endtask

  initial begin
    int nfr;
    beats_sent = 0;
    timed_out = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // Directed: named/numeric entities, strtol corner cases, tags, whitespace, eof.
    send_str("  <b>a&amp;&lt;&gt;&quot;&apos;</b> ", 0);
    send_str("&#65;&#x20AC;&#x1F600;&#;&#x;&#x0x;&#-1;&#99999999999999999999;", 0);
    send_str("&#x 0X7f;&#+;&bad;&&#\x00;", 1);
    send(8'hFF, 1);
    send_str("&amp", 1);
    set_size(16'd9);
    send_str("xy zz", 1);
    set_size(16'd16);
    send_str("hello world and more", 1);
    set_size(16'd65535);
    send_str("&#xFFFFFFFFFFFFFFFFFF;&#-99999999999999999999;", 1);
    // Random fragments.
    nfr = 0;
    while (beats_sent < 420) begin
      if (nfr % 8 == 7) set_size($urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 40))
                                                          : 16'($urandom_range(9, 65535)));
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(0, 2) == 0) send_entity();
        else send(pick_byte(), 0);
      end
      send(pick_byte(), 1);
      nfr++;
    end
    set_size(16'd1024);
    quiesce();
    $display("sent %0d input beats in %0d fragments, checked %0d output beats",
             beats_sent, sb.frags, sb.beats_checked);
    if (sb.errors == 0 && sb.expect_q.size() == 0) begin
      $display("html_text_cleaner_test passed");
    end else begin
      $display("html_text_cleaner_test failed");
    end
    $finish;
  end
endmodule
